@@ rtl/srtf_pkg.sv @@
// Shared types and fixed port widths of the SRTF scheduler.
// The top level and the sequencer import this package; it depends on nothing.
package srtf_pkg;

    localparam int PID_W       = 4;
    localparam int BURST_PORT_W = 10;
    localparam int TIME_PORT_W  = 16;

    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef enum logic {
        RK_ARRIVE = 1'b0,
        RK_TICK   = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARR_RD,
        S_ARR_WR,
        S_TICK_RD,
        S_SCAN,
        S_UPD
    } t_state;

    typedef struct packed {
        logic in_ready;    // idle, a request may be taken
        logic arr_rd;      // read the target slot of an arrival
        logic arr_wr;      // decide the arrival and report it
        logic run_rd;      // read the running slot's entry
        logic scan;        // one slot's data is back from the table
        logic scan_first;  // returned data belongs to the running slot
        logic scan_issue;  // issue the read of the slot under the counter
        logic upd;         // write back the winner and report the tick
    } t_seq_ctl;

endpackage

@@ rtl/srtf_preemptive_scheduler.sv @@
// Top level of the preemptive shortest-remaining-time-first scheduler.
// Depends on srtf_pkg, srtf_seq and srtf_rem_mem.
//
// One request at a time. An arrival reads its target slot, then decides and
// reports. A tick reads the running slot, scans every slot through one
// comparator with one table read per cycle, and writes back the winner. The
// scan over the single read port of the remaining-time table dominates a
// tick. A stalled result holds the sequence, because a request completes
// only into a free output register. On a tick the running slot is read
// first and holds the CPU unless a later slot is strictly shorter; among
// other slots the lowest index wins a tie. The winner loses one tick of
// remaining time, the clock advances and saturates at its maximum, and
// the report carries the slot, its remaining time, a first-run flag and a
// finish flag. An arrival to a busy slot, an out-of-range slot or with a
// zero burst (after cutting to BURST_BITS) is refused.
module srtf_preemptive_scheduler import srtf_pkg::*; #(
    parameter int MAX_PROCS  = 16,
    parameter int BURST_BITS = 10,
    parameter int TIME_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_operation,
    input  logic [PID_W-1:0]        i_process_id,
    input  logic [BURST_PORT_W-1:0] i_burst_length,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_result_kind,
    output logic                    o_accepted,
    output logic                    o_run_valid,
    output logic [PID_W-1:0]        o_run_process,
    output logic [BURST_PORT_W-1:0] o_remaining_left,
    output logic                    o_first_run,
    output logic                    o_finished,
    output logic [TIME_PORT_W-1:0]  o_time_now
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    t_seq_ctl              ctl;
    logic [CNT_W-1:0]      cnt;
    logic                  in_accept;
    logic                  out_free;

    // captured request
    logic                  r_op;
    logic [PID_W-1:0]      r_pid;
    logic [BURST_BITS-1:0] r_burst;
    logic                  pid_ok;

    // scheduler state
    logic [IDX_W-1:0]      r_run_slot;
    logic                  r_run_valid;
    logic [TIME_BITS-1:0]  r_clock;
    logic [TIME_BITS-1:0]  n_clock;
    logic [MAX_PROCS-1:0]  r_started;

    // scan registers
    logic                  r_have, n_have;
    logic [IDX_W-1:0]      r_sel, n_sel;
    logic [BURST_BITS-1:0] r_best, n_best;

    // table port
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr, mem_raddr;
    logic [BURST_BITS-1:0] mem_wdata, rd;

    logic                  arr_ok;
    logic [BURST_BITS-1:0] left;
    logic                  arr_commit, tick_commit;

    // output register
    logic                    r_out_valid;
    logic                    r_kind;
    logic                    r_accepted;
    logic                    r_run_v;
    logic [PID_W-1:0]        r_run_proc;
    logic [BURST_PORT_W-1:0] r_left;
    logic                    r_first;
    logic                    r_fin;
    logic [TIME_PORT_W-1:0]  r_time;

    srtf_seq #(
        .NUM   (MAX_PROCS),
        .CNT_W (CNT_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op_tick  (i_operation == OP_TICK),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_cnt      (cnt)
    );

    srtf_rem_mem #(
        .DEPTH (MAX_PROCS),
        .AW    (IDX_W),
        .DW    (BURST_BITS)
    ) u_rem_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign o_in_stall  = !ctl.in_ready;
    assign in_accept   = i_in_valid && ctl.in_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign arr_commit  = ctl.arr_wr && out_free;
    assign tick_commit = ctl.upd && out_free;

    // Hold the request for the whole sequence; cut the burst to BURST_BITS.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_operation;
            r_pid   <= i_process_id;
            r_burst <= BURST_BITS'(i_burst_length);
        end
    end

    assign pid_ok = (32'(r_pid) < 32'(MAX_PROCS));
    assign arr_ok = pid_ok && (r_burst != '0) && (rd == '0);
    assign left   = r_best - 1'b1;

    // Table read address: arrival slot, running slot, then slot 0 upward.
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_run_slot;
        if (ctl.arr_rd) begin
            mem_re    = pid_ok;
            mem_raddr = IDX_W'(r_pid);
        end else if (ctl.run_rd) begin
            mem_re    = 1'b1;
            mem_raddr = r_run_slot;
        end else if (ctl.scan_issue) begin
            mem_re    = 1'b1;
            mem_raddr = cnt[IDX_W-1:0];
        end
    end

    // Table write: accepted arrival, or the winner's decremented time.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sel;
        mem_wdata = left;
        if (arr_commit) begin
            mem_we    = arr_ok;
            mem_waddr = IDX_W'(r_pid);
            mem_wdata = r_burst;
        end else if (tick_commit) begin
            mem_we    = r_have;
        end
    end

    // Shared compare: the running slot seeds the search, later slots must
    // be strictly shorter to take over.
    always_comb begin
        n_have = r_have;
        n_sel  = r_sel;
        n_best = r_best;
        if (ctl.scan) begin
            if (ctl.scan_first) begin
                n_have = r_run_valid && (rd != '0);
                n_sel  = r_run_slot;
                n_best = rd;
            end else if ((rd != '0) && (!r_have || (rd < r_best))) begin
                n_have = 1'b1;
                n_sel  = IDX_W'(cnt - 1'b1);
                n_best = rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_have <= n_have;
        r_sel  <= n_sel;
        r_best <= n_best;
    end

    // Advance the clock, saturating at all ones.
    assign n_clock = (r_clock != '1) ? r_clock + 1'b1 : r_clock;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_slot  <= '0;
            r_run_valid <= 1'b0;
            r_clock     <= '0;
            r_started   <= '0;
        end else if (arr_commit) begin
            if (arr_ok) begin
                r_started[IDX_W'(r_pid)] <= 1'b0;
            end
        end else if (tick_commit) begin
            r_clock <= n_clock;
            if (r_have) begin
                r_started[r_sel] <= 1'b1;
                r_run_slot       <= r_sel;
                r_run_valid      <= (left != '0);
            end else begin
                r_run_valid <= 1'b0;
            end
        end
    end

    // Output register: drop on take, load on commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (arr_commit || tick_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (arr_commit) begin
            r_kind     <= RK_ARRIVE;
            r_accepted <= arr_ok;
            r_run_v    <= 1'b0;
            r_run_proc <= '0;
            r_left     <= '0;
            r_first    <= 1'b0;
            r_fin      <= 1'b0;
            r_time     <= '0;
        end else if (tick_commit) begin
            r_kind     <= RK_TICK;
            r_accepted <= 1'b0;
            r_run_v    <= r_have;
            r_run_proc <= r_have ? PID_W'(r_sel) : '0;
            r_left     <= r_have ? BURST_PORT_W'(left) : '0;
            r_first    <= r_have && !r_started[r_sel];
            r_fin      <= r_have && (left == '0);
            r_time     <= TIME_PORT_W'(n_clock);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_accepted       = r_accepted;
    assign o_run_valid      = r_run_v;
    assign o_run_process    = r_run_proc;
    assign o_remaining_left = r_left;
    assign o_first_run      = r_first;
    assign o_finished       = r_fin;
    assign o_time_now       = r_time;

    // The captured operation steers the sequence it started.
    a_op_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.arr_rd |-> (r_op == OP_ARRIVE))
        else $error("arrival sequence running for a tick request");

    // Once a request is taken the block stops taking more.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("request taken while another is in progress");

    // An acknowledgement never carries run information.
    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == RK_ARRIVE)) |-> (!r_run_v && (r_time == '0)))
        else $error("arrival acknowledgement carries tick fields");

    // A finish report names a process that ran down to zero.
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fin) |-> (r_run_v && (r_left == '0)))
        else $error("finish flag without a completed process");

    // A tick always leaves the clock past zero.
    a_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_commit |=> (r_clock != '0))
        else $error("clock failed to advance on a tick");

endmodule

@@ rtl/srtf_rem_mem.sv @@
// Remaining-time table: one write port, one registered read port.
// Per-entry valid bits make never-written entries read as zero (inactive).
module srtf_rem_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/srtf_seq.sv @@
// Sequencer of the SRTF scheduler: state machine and slot scan counter.
// Uses srtf_pkg for the state enum and the control struct.
module srtf_seq import srtf_pkg::*; #(
    parameter int NUM   = 16,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_op_tick,
    input  logic             i_out_free,
    output t_seq_ctl         o_ctl,
    output logic [CNT_W-1:0] o_cnt
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_op_tick ? S_TICK_RD : S_ARR_RD;
                end
            end
            S_ARR_RD: begin
                n_state = S_ARR_WR;
            end
            S_ARR_WR: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK_RD: begin
                n_cnt   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctl = '0;
        case (r_state)
            S_IDLE:    o_ctl.in_ready = 1'b1;
            S_ARR_RD:  o_ctl.arr_rd   = 1'b1;
            S_ARR_WR:  o_ctl.arr_wr   = 1'b1;
            S_TICK_RD: o_ctl.run_rd   = 1'b1;
            S_SCAN: begin
                o_ctl.scan       = 1'b1;
                o_ctl.scan_first = (r_cnt == '0);
                o_ctl.scan_issue = (r_cnt != LAST);
            end
            S_UPD:     o_ctl.upd      = 1'b1;
            default:   o_ctl          = '0;
        endcase
    end

    assign o_cnt = r_cnt;

endmodule

@@ tb/srtf_preemptive_scheduler_tb.sv @@
// Self-checking testbench for the SRTF preemptive scheduler.
// Imports srtf_pkg and instantiates srtf_preemptive_scheduler.
// The scheduler's behavior is mirrored in local state, and every report is checked in order.
module srtf_preemptive_scheduler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import srtf_pkg::*;

    localparam int NPROC   = 16;
    localparam int BURST_W = 10;
    localparam int TIME_W  = 16;

    // Generous bound: about a thousand requests, plus random idle and stall
    // gaps and one long receiver hold.
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_TAIL  = 40;
    localparam int HOLD_CYCLES = 400;

    // One report as the scheduler produces it, field for field.
    typedef struct packed {
        t_kind                   kind;
        logic                    accepted;
        logic                    run_valid;
        logic [PID_W-1:0]        run_process;
        logic [BURST_PORT_W-1:0] remaining_left;
        logic                    first_run;
        logic                    finished;
        logic [TIME_PORT_W-1:0]  time_now;
    } t_sched_report;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_stall;
    logic                    i_operation    = OP_ARRIVE;
    logic [PID_W-1:0]        i_process_id   = '0;
    logic [BURST_PORT_W-1:0] i_burst_length = '0;
    logic                    o_out_valid;
    logic                    i_out_stall    = 1'b0;
    logic                    o_result_kind;
    logic                    o_accepted;
    logic                    o_run_valid;
    logic [PID_W-1:0]        o_run_process;
    logic [BURST_PORT_W-1:0] o_remaining_left;
    logic                    o_first_run;
    logic                    o_finished;
    logic [TIME_PORT_W-1:0]  o_time_now;

    // Mirror of the scheduler state, advanced once per accepted request.
    logic [BURST_W-1:0] remain_tbl [NPROC];
    logic               started    [NPROC];
    logic [PID_W-1:0]   cur_slot   = '0;
    logic               cur_valid  = 1'b0;
    logic [TIME_W-1:0]  sim_clock  = '0;

    // Reports predicted for accepted requests, oldest first.
    t_sched_report report_q [$];

    int idle_pct       = 0;   // chance per cycle that the sender holds off
    int stall_pct      = 0;   // chance per cycle that the receiver stalls
    int hold_total     = 0;   // receiver stalls until hold_done reaches this
    int hold_done      = 0;
    int mismatch_count = 0;
    int report_index   = 0;
    int cycle_count    = 0;

    srtf_preemptive_scheduler #(
        .MAX_PROCS (NPROC),
        .BURST_BITS(BURST_W),
        .TIME_BITS (TIME_W)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_process_id    (i_process_id),
        .i_burst_length  (i_burst_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_accepted      (o_accepted),
        .o_run_valid     (o_run_valid),
        .o_run_process   (o_run_process),
        .o_remaining_left(o_remaining_left),
        .o_first_run     (o_first_run),
        .o_finished      (o_finished),
        .o_time_now      (o_time_now)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < NPROC; i++) begin
            remain_tbl[i] = '0;
            started[i]    = 1'b0;
        end
    end

    // Apply one request to the mirrored scheduler and return its report.
    // An arrival loads a free slot and clears its started mark. A tick lets
    // the running slot keep the CPU unless another slot is strictly shorter,
    // otherwise the lowest shortest slot wins; the clock saturates at all ones.
    function automatic t_sched_report predict_schedule(
        input t_op op, input logic [PID_W-1:0] pid, input logic [BURST_PORT_W-1:0] burst
    );
        t_sched_report      rep;
        logic               have;
        logic [PID_W-1:0]   sel;
        logic [BURST_W-1:0] best;
        logic [BURST_W-1:0] cut;
        logic [BURST_W-1:0] left;
        int                 i;
        rep  = '0;
        have = 1'b0;
        sel  = '0;
        best = '0;
        cut  = BURST_W'(burst);
        if (op == OP_ARRIVE) begin
            rep.kind = RK_ARRIVE;
            if (int'(pid) < NPROC && cut != 0 && remain_tbl[pid] == 0) begin
                remain_tbl[pid] = cut;
                started[pid]    = 1'b0;
                rep.accepted    = 1'b1;
            end
        end else begin
            if (cur_valid && remain_tbl[cur_slot] != 0) begin
                have = 1'b1;
                sel  = cur_slot;
                best = remain_tbl[cur_slot];
            end
            for (i = 0; i < NPROC; i++) begin
                if (remain_tbl[i] != 0 && (!have || remain_tbl[i] < best)) begin
                    have = 1'b1;
                    sel  = PID_W'(i);
                    best = remain_tbl[i];
                end
            end
            if (sim_clock != '1)
                sim_clock = sim_clock + 1'b1;
            rep.kind     = RK_TICK;
            rep.time_now = TIME_PORT_W'(sim_clock);
            if (have) begin
                left               = best - 1'b1;
                rep.run_valid      = 1'b1;
                rep.run_process    = sel;
                rep.remaining_left = BURST_PORT_W'(left);
                rep.first_run      = !started[sel];
                rep.finished       = (left == 0);
                started[sel]       = 1'b1;
                remain_tbl[sel]    = left;
                cur_slot           = sel;
                cur_valid          = (left != 0);
            end else begin
                cur_valid = 1'b0;
            end
        end
        return rep;
    endfunction

    function automatic string report_text(input t_sched_report r);
        return $sformatf("kind=%0d acc=%0d run=%0d pid=%0d left=%0d first=%0d fin=%0d t=%0d",
                         r.kind, r.accepted, r.run_valid, r.run_process,
                         r.remaining_left, r.first_run, r.finished, r.time_now);
    endfunction

    // Offer one request, optionally after random idle cycles, and hold it
    // until the scheduler takes it. Valid stays high on return so that a
    // following request goes out back to back.
    task automatic issue_request(
        input t_op op, input logic [PID_W-1:0] pid, input logic [BURST_PORT_W-1:0] burst
    );
        t_sched_report rep;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_process_id   <= pid;
        i_burst_length <= burst;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        rep = predict_schedule(op, pid, burst);
        report_q.insert(report_q.size(), rep);
    endtask

    // Drop valid and wait until every predicted report has come back.
    task automatic wait_reports_drained();
        i_in_valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Hand-picked sequence: idle tick, extreme bursts and slots, busy and
    // zero-burst refusals, preemption, both tie rules, completion and a
    // re-arrival into a finished slot. Slot out of range and a burst wider
    // than the table cannot be expressed at these port widths.
    task automatic test_directed_cases();
        idle_pct  = 0;
        stall_pct = 0;
        issue_request(OP_TICK,   4'd0,  10'd0);      // nothing active: idle tick
        issue_request(OP_ARRIVE, 4'd0,  10'd1023);   // longest burst, lowest slot
        issue_request(OP_ARRIVE, 4'd0,  10'd5);      // slot busy: refuse
        issue_request(OP_ARRIVE, 4'd15, 10'd0);      // zero burst: refuse
        issue_request(OP_ARRIVE, 4'd15, 10'd3);
        issue_request(OP_TICK,   4'd15, 10'h3ff);    // shorter slot 15 takes the CPU
        issue_request(OP_ARRIVE, 4'd5,  10'd2);
        issue_request(OP_TICK,   4'd0,  10'd0);      // tie with running slot: keep it
        issue_request(OP_TICK,   4'd0,  10'd0);      // slot 15 finishes
        issue_request(OP_TICK,   4'd0,  10'd0);
        issue_request(OP_ARRIVE, 4'd3,  10'd1);
        issue_request(OP_TICK,   4'd0,  10'd0);      // running slot 5 holds against slot 3
        issue_request(OP_ARRIVE, 4'd2,  10'd1);
        issue_request(OP_TICK,   4'd0,  10'd0);      // nobody running: lower slot wins tie
        issue_request(OP_TICK,   4'd0,  10'd0);
        issue_request(OP_ARRIVE, 4'd15, 10'd1);      // reuse a finished slot
        issue_request(OP_TICK,   4'd0,  10'd0);
        issue_request(OP_TICK,   4'd0,  10'd0);      // long job gets its first run
        issue_request(OP_ARRIVE, 4'd7,  10'd1000);
        issue_request(OP_TICK,   4'd0,  10'd0);
        wait_reports_drained();
    endtask

    // Mostly well-formed traffic: arrivals into free slots with short bursts
    // so that jobs complete, preempt and tie often, plus a few long jobs,
    // and some noise aimed at busy slots or carrying zero bursts.
    task automatic run_mixed_traffic(input int n_items, input int arrive_pct);
        int               roll;
        int               start;
        int               slot;
        int               long_jobs;
        int               i;
        logic [PID_W-1:0] pid;
        repeat (n_items) begin
            roll  = $urandom_range(99);
            start = $urandom_range(NPROC - 1);
            slot  = -1;
            long_jobs = 0;
            for (i = 0; i < NPROC; i++)
                if (remain_tbl[i] > 100)
                    long_jobs++;
            if (roll < 6) begin
                issue_request(OP_ARRIVE, PID_W'($urandom), '0);
            end else if (roll < 14) begin
                // aim at an active slot when there is one
                for (i = 0; i < NPROC; i++)
                    if (slot < 0 && remain_tbl[(start + i) % NPROC] != 0)
                        slot = (start + i) % NPROC;
                pid = (slot < 0) ? PID_W'($urandom) : PID_W'(slot);
                issue_request(OP_ARRIVE, pid,
                              (slot < 0) ? '0 : BURST_PORT_W'($urandom));
            end else begin
                if (roll < 14 + arrive_pct)
                    for (i = 0; i < NPROC; i++)
                        if (slot < 0 && remain_tbl[(start + i) % NPROC] == 0)
                            slot = (start + i) % NPROC;
                if (slot < 0)
                    issue_request(OP_TICK, PID_W'($urandom), BURST_PORT_W'($urandom));
                else if (long_jobs < 2 && $urandom_range(15) == 0)
                    issue_request(OP_ARRIVE, PID_W'(slot),
                                  BURST_PORT_W'($urandom_range(1, 1023)));
                else
                    issue_request(OP_ARRIVE, PID_W'(slot),
                                  BURST_PORT_W'($urandom_range(1, 6)));
            end
        end
    endtask

    // Random traffic under each idle and stall pattern in turn.
    task automatic test_random_traffic();
        idle_pct  = 0;
        stall_pct = 0;
        run_mixed_traffic(250, 18);
        idle_pct  = 67;
        run_mixed_traffic(250, 18);
        idle_pct  = 0;
        stall_pct = 67;
        run_mixed_traffic(250, 18);
        idle_pct  = 20;
        stall_pct = 20;
        run_mixed_traffic(250, 18);
        wait_reports_drained();
    endtask

    // Block the result side for a long stretch while requests keep coming,
    // so the scheduler fills up and stalls its input; then let it drain.
    task automatic test_output_backpressure();
        idle_pct   = 0;
        stall_pct  = 0;
        hold_total = hold_done + HOLD_CYCLES;
        run_mixed_traffic(12, 30);
        wait_reports_drained();
        run_mixed_traffic(12, 30);
        wait_reports_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        // allow for any stray report the block might still push out
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatch_count == 0 && report_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: hold off for the requested stretch, otherwise stall at random.
    always @(posedge i_clk) begin
        if (hold_done < hold_total) begin
            hold_done = hold_done + 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check each accepted report against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_sched_report got;
            t_sched_report want;
            got.kind           = t_kind'(o_result_kind);
            got.accepted       = o_accepted;
            got.run_valid      = o_run_valid;
            got.run_process    = o_run_process;
            got.remaining_left = o_remaining_left;
            got.first_run      = o_first_run;
            got.finished       = o_finished;
            got.time_now       = o_time_now;
            if (report_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("report %0d unexpected: got %s", report_index, report_text(got));
            end else begin
                want = report_q.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("report %0d mismatch: expected %s, got %s",
                                 report_index, report_text(want), report_text(got));
                end
            end
            report_index++;
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
